>>> rtl/stt_pkg.sv
// Shared types, character codes and helper functions for the source text tokenizer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package stt_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned LINE_BITS   = 16;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned TDATA_W     = 56;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_NUMBER   = 6'b000010,
    MODE_FRACTION = 6'b000100,
    MODE_IDENT    = 6'b001000,
    MODE_STRING   = 6'b010000,
    MODE_COMMENT  = 6'b100000
  } lex_mode_e;

  typedef enum logic [2:0] {
    KIND_INTEGER    = 3'd0,
    KIND_IDENT      = 3'd1,
    KIND_STRING     = 3'd2,
    KIND_CHAR       = 3'd3,
    KIND_EOF        = 3'd4,
    KIND_ERR_STRING = 3'd5,
    KIND_ERR_FRAC   = 3'd6,
    KIND_ERR_COMMENT = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [7:0]             char_value;
  } rec_t;

  // One queue entry holds every result of one input item.
  typedef struct packed {
    rec_t rec0;
    rec_t rec1;
    logic two;
  } entry_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return (c inside {[CH_LC_A:CH_LC_Z]}) || (c inside {[CH_UC_A:CH_UC_Z]}) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_ident_start(c) || is_digit(c);
  endfunction

  function automatic rec_t mk_rec(input kind_e kind, input logic [OFFSET_BITS-1:0] start,
                                  input logic [OFFSET_BITS-1:0] len,
                                  input logic [LINE_BITS-1:0] line,
                                  input logic [7:0] ch);
    rec_t r;
    r.kind       = kind;
    r.start      = start;
    r.len        = len;
    r.line       = line;
    r.char_value = ch;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: front end, result queue and output stage.
// Depends on stt_pkg, stt_front, stt_fifo and stt_back.
`default_nettype none

// The tokenizer takes one source byte per beat on the slave stream (tuser high marks
// the end of the source and carries no byte) and returns token and error records on
// the master stream, tuser carrying the record kind and tlast marking the final record
// caused by one input beat. The
// front end handles each byte as it is taken, so bytes flow at one per cycle for as
// long as the four-entry result queue has room. The output side delivers one record
// per cycle while the master stream is ready; a byte that ends one token and forms a
// character token in the same beat, or an end-of-source beat with a pending token,
// yields two records, sent as two beats. Results pass the queue and output register.
module source_text_tokenizer_top import stt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [7:0] text_byte
  input  wire logic               s_axis_tuser,   // [0] end_of_source
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [15:0] start_offset, [31:16] text_length, [47:32] line_number, [55:48] char_value
  output logic [TDATA_W-1:0]      m_axis_tdata,
  output logic [2:0]              m_axis_tuser,   // [2:0] kind
  output logic                    m_axis_tlast    // last_of_run
);

  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_wdata, q_head;
  rec_t   out_rec;

  stt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_eos_i   (s_axis_tuser),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (q_push),
    .entry_o    (q_wdata)
  );

  stt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wdata),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_rec_o   (out_rec),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {out_rec.char_value, out_rec.line, out_rec.len, out_rec.start};
  assign m_axis_tuser = out_rec.kind;

  // The front end never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("result queue written while full");

  // An end-of-source beat always produces an entry whose final record is EOF.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |->
      (q_push && (q_wdata.two ? (q_wdata.rec1.kind == KIND_EOF)
                              : (q_wdata.rec0.kind == KIND_EOF))))
    else $error("end of source did not produce an EOF record");

  // The output stage only pops an entry it is actually moving into the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("result queue popped while empty");

endmodule

`default_nettype wire

>>> rtl/stt_front.sv
// Front end of the tokenizer: accepts one byte per beat, tracks the lexing mode and
// positions, and builds the results of each byte as one queue entry. Uses stt_pkg.
`default_nettype none

module stt_front import stt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_eos_i,
  input  wire logic       q_full_i,
  output logic            in_ready_o,
  output logic            push_o,
  output entry_t          entry_o
);

  lex_mode_e              mode_q, mode_d;
  logic [OFFSET_BITS-1:0] ts_q, ts_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic                   cjo_q, cjo_d;

  logic                   accept;
  logic                   relex;
  logic                   e0_v, e1_v;
  rec_t                   e0, e1;
  logic [OFFSET_BITS-1:0] span;
  logic [OFFSET_BITS-1:0] str_start;
  logic [OFFSET_BITS-1:0] str_len;
  logic [LINE_BITS-1:0]   line_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // The token start never passes the byte position, so the plain difference is the span.
  assign span      = pos_q - ts_q;
  assign str_start = (ts_q < OFF_MAX) ? ts_q + OFFSET_BITS'(1) : ts_q;
  assign str_len   = (pos_q > str_start) ? pos_q - str_start : '0;
  assign line_inc  = (line_q < LINE_MAX) ? line_q + LINE_BITS'(1) : line_q;

  always_comb begin
    mode_d = mode_q;
    ts_d   = ts_q;
    pos_d  = (pos_q < OFF_MAX) ? pos_q + OFFSET_BITS'(1) : pos_q;
    line_d = line_q;
    cjo_d  = cjo_q;
    relex  = 1'b0;
    e0_v   = 1'b0;
    e1_v   = 1'b0;
    e0     = mk_rec(KIND_INTEGER, ts_q, span, line_q, 8'd0);
    e1     = mk_rec(KIND_CHAR, pos_q, OFFSET_BITS'(1), line_q, in_byte_i);

    if (in_eos_i) begin
      // Flush what is pending, then always end with the end-of-file record.
      e1_v = 1'b1;
      e1   = mk_rec(KIND_EOF, pos_q, '0, line_q, 8'd0);
      case (mode_q)
        MODE_NUMBER: begin
          e0_v = 1'b1;
        end
        MODE_IDENT: begin
          e0_v = 1'b1;
          e0   = mk_rec(KIND_IDENT, ts_q, span, line_q, 8'd0);
        end
        MODE_STRING: begin
          e0_v = 1'b1;
          e0   = mk_rec(KIND_ERR_STRING, ts_q, '0, line_q, 8'd0);
        end
        MODE_COMMENT: begin
          e0_v = cjo_q;
          e0   = mk_rec(KIND_ERR_COMMENT, ts_q, '0, line_q, 8'd0);
        end
        default: begin
          e0_v = 1'b0;
        end
      endcase
      mode_d = MODE_IDLE;
      ts_d   = '0;
      pos_d  = '0;
      line_d = LINE_ONE;
      cjo_d  = 1'b0;
    end else begin
      case (mode_q)
        MODE_NUMBER: begin
          if (in_byte_i == CH_DOT) begin
            e0_v   = 1'b1;
            e0     = mk_rec(KIND_ERR_FRAC, ts_q, '0, line_q, 8'd0);
            mode_d = MODE_FRACTION;
          end else if (!is_digit(in_byte_i)) begin
            e0_v  = 1'b1;
            relex = 1'b1;
          end
        end
        MODE_FRACTION: begin
          relex = !is_digit(in_byte_i);
        end
        MODE_IDENT: begin
          if (!is_ident_char(in_byte_i)) begin
            e0_v  = 1'b1;
            e0    = mk_rec(KIND_IDENT, ts_q, span, line_q, 8'd0);
            relex = 1'b1;
          end
        end
        MODE_STRING: begin
          if (in_byte_i == CH_QUOTE) begin
            e0_v   = 1'b1;
            e0     = mk_rec(KIND_STRING, str_start, str_len, line_q, 8'd0);
            mode_d = MODE_IDLE;
          end else if (in_byte_i == CH_LF) begin
            line_d = line_inc;
          end
        end
        MODE_COMMENT: begin
          cjo_d = 1'b0;
          relex = (in_byte_i == CH_LF);
        end
        default: begin
          relex = 1'b1;
        end
      endcase

      // A byte that followed and ended a token, or any byte between tokens, starts over from idle.
      if (relex) begin
        mode_d = MODE_IDLE;
        ts_d   = pos_q;
        if (in_byte_i == CH_HASH) begin
          mode_d = MODE_COMMENT;
          cjo_d  = 1'b1;
        end else if (in_byte_i == CH_QUOTE) begin
          mode_d = MODE_STRING;
        end else if (in_byte_i == CH_LF) begin
          line_d = line_inc;
        end else if (in_byte_i == CH_SPACE || in_byte_i == CH_CR || in_byte_i == CH_TAB) begin
          mode_d = MODE_IDLE;
        end else if (is_digit(in_byte_i)) begin
          mode_d = MODE_NUMBER;
        end else if (is_ident_start(in_byte_i)) begin
          mode_d = MODE_IDENT;
        end else begin
          e1_v = 1'b1;
        end
      end
    end
  end

  always_comb begin
    push_o = accept && (e0_v || e1_v);
    if (e0_v) begin
      entry_o.rec0 = e0;
      entry_o.rec1 = e1;
      entry_o.two  = e1_v;
    end else begin
      entry_o.rec0 = e1;
      entry_o.rec1 = e1;
      entry_o.two  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      ts_q   <= '0;
      pos_q  <= '0;
      line_q <= LINE_ONE;
      cjo_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      ts_q   <= ts_d;
      pos_q  <= pos_d;
      line_q <= line_d;
      cjo_q  <= cjo_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stt_fifo.sv
// Short queue of result entries between the tokenizer front end and the output stage.
// Uses entry_t and the depth constants from stt_pkg.
`default_nettype none

module stt_fifo import stt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  entry_t    entry_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      empty_o,
  output entry_t    head_o
);

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/stt_back.sv
// Output stage of the tokenizer: splits each queue entry into one or two result beats
// and holds them in an output register. Uses rec_t and entry_t from stt_pkg.
`default_nettype none

module stt_back import stt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  entry_t    head_i,
  input  wire logic empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output rec_t      out_rec_o,
  output logic      out_last_o,
  input  wire logic out_ready_i
);

  logic valid_q, valid_d;
  logic sel_q, sel_d;
  rec_t rec_q;
  logic last_q;
  logic load, take, last;

  assign load  = !valid_q || out_ready_i;
  assign take  = load && !empty_i;
  assign last  = sel_q || !head_i.two;
  assign pop_o = take && last;

  assign out_valid_o = valid_q;
  assign out_rec_o   = rec_q;
  assign out_last_o  = last_q;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (load) begin
      valid_d = !empty_i;
    end
    if (take) begin
      sel_d = !last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rec_q  <= sel_q ? head_i.rec1 : head_i.rec0;
      last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

endmodule

`default_nettype wire
